>>> design/thpid_pkg.sv
// ----------------------------------------------------------------------------
// Thermistor PID heater control package
// Shared constants, thermistor table, register indexes and configuration type.
// ----------------------------------------------------------------------------
package thpid_pkg;

  localparam int unsigned ERROR_WINDOW = 3;
  localparam int unsigned TABLE_POINTS = 20;
  localparam int unsigned IDX_W        = (ERROR_WINDOW > 1) ? $clog2(ERROR_WINDOW) : 1;
  localparam int unsigned SEG_W        = $clog2(TABLE_POINTS);

  localparam int unsigned ADC_W   = 10;
  localparam int unsigned TEMP_W  = 14;
  localparam int unsigned DUTY_W  = 7;
  localparam int unsigned ERR_W   = 16;
  localparam int unsigned ISUM_W  = 40;
  localparam int unsigned MUL_W   = 21;
  localparam int unsigned PROD_W  = 2 * MUL_W;
  localparam int unsigned GCNT_W  = 3;

  localparam int unsigned PADDR_W = 5;
  localparam int unsigned PDATA_W = 32;

  localparam logic [7:0]        ROOM_TEMP_DEG = 8'd30;
  localparam logic [TEMP_W-1:0] MAX_TEMP_16   = 14'd3680;
  localparam logic [DUTY_W-1:0] MAX_DUTY      = 7'd100;
  localparam logic [GCNT_W-1:0] GLITCH_MAX    = 3'd4;
  localparam logic [GCNT_W-1:0] GLITCH_LIMIT  = 3'd3;

  localparam int unsigned       ADC_STEP     = 53;
  localparam int unsigned       RECIP_SHIFT  = 25;
  localparam logic [MUL_W-1:0]  RECIP_53     = 21'd633103;

  localparam logic [2:0] REG_TARGET   = 3'd0;
  localparam logic [2:0] REG_CUTOFF   = 3'd1;
  localparam logic [2:0] REG_PGAIN    = 3'd2;
  localparam logic [2:0] REG_IGAIN    = 3'd3;
  localparam logic [2:0] REG_DGAIN    = 3'd4;

  localparam logic [ADC_W-1:0] CUTOFF_RESET = 10'd1000;

  typedef struct packed {
    logic [7:0]       target_temp;
    logic [ADC_W-1:0] adc_cutoff;
    logic [15:0]      prop_gain;
    logic [15:0]      integral_gain;
    logic [15:0]      deriv_gain;
  } cfg_t;

  function automatic logic [ADC_W-1:0] lut_adc(input logic [SEG_W-1:0] seg);
    logic [ADC_W+SEG_W-1:0] v;
    v = (ADC_W+SEG_W)'(1) + (ADC_W+SEG_W)'(ADC_STEP) * (ADC_W+SEG_W)'(seg);
    return v[ADC_W-1:0];
  endfunction

  function automatic logic [9:0] lut_deg(input logic [SEG_W-1:0] seg);
    logic [9:0] d;
    unique case (seg)
      5'd0:    d = 10'd713;
      5'd1:    d = 10'd236;
      5'd2:    d = 10'd195;
      5'd3:    d = 10'd172;
      5'd4:    d = 10'd157;
      5'd5:    d = 10'd144;
      5'd6:    d = 10'd134;
      5'd7:    d = 10'd125;
      5'd8:    d = 10'd117;
      5'd9:    d = 10'd110;
      5'd10:   d = 10'd103;
      5'd11:   d = 10'd96;
      5'd12:   d = 10'd89;
      5'd13:   d = 10'd83;
      5'd14:   d = 10'd75;
      5'd15:   d = 10'd68;
      5'd16:   d = 10'd59;
      5'd17:   d = 10'd48;
      5'd18:   d = 10'd34;
      5'd19:   d = 10'd3;
      default: d = 10'd3;
    endcase
    return d;
  endfunction

endpackage

>>> design/thpid_regs.sv
// ----------------------------------------------------------------------------
// Thermistor PID configuration registers
// APB-style register file holding target, cutoff and the three PID gains.
// ----------------------------------------------------------------------------
module thpid_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [thpid_pkg::PADDR_W-1:0]   paddr,
  input  logic [thpid_pkg::PDATA_W-1:0]   pwdata,
  output logic [thpid_pkg::PDATA_W-1:0]   prdata,
  output logic                            pready,
  output thpid_pkg::cfg_t                 cfg_o
);

  thpid_pkg::cfg_t cfg_q, cfg_d;
  logic            wr_en;
  logic [2:0]      reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[thpid_pkg::PADDR_W-1:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        thpid_pkg::REG_TARGET: cfg_d.target_temp   = pwdata[7:0];
        thpid_pkg::REG_CUTOFF: cfg_d.adc_cutoff    = pwdata[thpid_pkg::ADC_W-1:0];
        thpid_pkg::REG_PGAIN:  cfg_d.prop_gain     = pwdata[15:0];
        thpid_pkg::REG_IGAIN:  cfg_d.integral_gain = pwdata[15:0];
        thpid_pkg::REG_DGAIN:  cfg_d.deriv_gain    = pwdata[15:0];
        default:               cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      thpid_pkg::REG_TARGET: prdata = thpid_pkg::PDATA_W'(cfg_q.target_temp);
      thpid_pkg::REG_CUTOFF: prdata = thpid_pkg::PDATA_W'(cfg_q.adc_cutoff);
      thpid_pkg::REG_PGAIN:  prdata = thpid_pkg::PDATA_W'(cfg_q.prop_gain);
      thpid_pkg::REG_IGAIN:  prdata = thpid_pkg::PDATA_W'(cfg_q.integral_gain);
      thpid_pkg::REG_DGAIN:  prdata = thpid_pkg::PDATA_W'(cfg_q.deriv_gain);
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_temp   <= '0;
      cfg_q.adc_cutoff    <= thpid_pkg::CUTOFF_RESET;
      cfg_q.prop_gain     <= '0;
      cfg_q.integral_gain <= '0;
      cfg_q.deriv_gain    <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> design/thermistor_pid_heater_control_unit.sv
// ----------------------------------------------------------------------------
// Thermistor PID heater control unit
// Linearizes one thermistor sample per control tick and sets the heater duty.
//
// Input channel: in_valid_i/in_ready_o with adc_sample_i. Output channel:
// out_valid_o/out_ready_i with heater_duty_o, temperature_o, heater_active_o,
// sensor_fault_o and runaway_fault_o; one result transaction per input
// transaction. Configuration goes through the APB-style port: target
// temperature, ADC glitch cutoff and the three Q8.8 PID gains; write it only
// while the block is idle.
// A small sequencer drives one shared 21x21 signed multiplier with a
// registered product. The table segment search visits one point a cycle;
// a glitch sample while control is off takes the shortest path and an
// active sample in the last segment the longest. The sequencer takes no new
// sample until its result is loaded. in_ready_o is high only while the
// sequencer waits. The output register holds the finished result; a new
// sample is taken while it waits, and a stalled receiver holds the next
// result in the sequencer. Reset clears the control state: control off,
// faults clear, temperature zero, error window and integral zero, and the
// registers go to their reset values; datapath and output data registers are not reset.
// ----------------------------------------------------------------------------
module thermistor_pid_heater_control_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [thpid_pkg::ADC_W-1:0]        adc_sample_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [thpid_pkg::DUTY_W-1:0]       heater_duty_o,
  output logic [thpid_pkg::TEMP_W-1:0]       temperature_o,
  output logic                               heater_active_o,
  output logic                               sensor_fault_o,
  output logic                               runaway_fault_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [thpid_pkg::PADDR_W-1:0]      paddr,
  input  logic [thpid_pkg::PDATA_W-1:0]      pwdata,
  output logic [thpid_pkg::PDATA_W-1:0]      prdata,
  output logic                               pready
);

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_ENTRY  = 13'b0000000000010,
    S_ISUB   = 13'b0000000000100,
    S_SAMPLE = 13'b0000000001000,
    S_SEARCH = 13'b0000000010000,
    S_SCALE  = 13'b0000000100000,
    S_INTERP = 13'b0000001000000,
    S_MODE   = 13'b0000010000000,
    S_IADD   = 13'b0000100000000,
    S_PTERM  = 13'b0001000000000,
    S_DTERM  = 13'b0010000000000,
    S_DUTY   = 13'b0100000000000,
    S_DONE   = 13'b1000000000000
  } state_e;

  localparam int unsigned TW = thpid_pkg::TEMP_W;
  localparam int unsigned PW = thpid_pkg::PROD_W;
  localparam int unsigned MW = thpid_pkg::MUL_W;
  localparam int unsigned IW = thpid_pkg::ISUM_W;
  localparam int unsigned EW = thpid_pkg::ERR_W;

  thpid_pkg::cfg_t cfg;

  state_e                          state_q, state_d;
  logic                            mode_q, mode_d;
  logic [thpid_pkg::GCNT_W-1:0]    glitch_q, glitch_d;
  logic                            sflt_q, sflt_d;
  logic                            rflt_q, rflt_d;
  logic [TW-1:0]                   cur_q, cur_d;
  logic [TW-1:0]                   prev_q, prev_d;
  logic signed [EW-1:0]            win_q [thpid_pkg::ERROR_WINDOW];
  logic signed [EW-1:0]            win_d [thpid_pkg::ERROR_WINDOW];
  logic [thpid_pkg::IDX_W-1:0]     idx_q, idx_d;
  logic [IW-1:0]                   isum_q, isum_d;
  logic [thpid_pkg::DUTY_W-1:0]    duty_q, duty_d;
  logic [thpid_pkg::ADC_W-1:0]     x_q, x_d;
  logic [thpid_pkg::SEG_W-1:0]     seg_q, seg_d;
  logic signed [PW-1:0]            acc_q, acc_d;
  logic signed [PW-1:0]            mul_q;
  logic signed [MW-1:0]            mul_a, mul_b;
  logic signed [PW-1:0]            mul_p;

  logic                            out_valid_q, out_valid_d;
  logic [thpid_pkg::DUTY_W-1:0]    out_duty_q, out_duty_d;
  logic [TW-1:0]                   out_temp_q, out_temp_d;
  logic                            out_act_q, out_act_d;
  logic                            out_sflt_q, out_sflt_d;
  logic                            out_rflt_q, out_rflt_d;

  logic signed [EW-1:0]            err;
  logic signed [EW-1:0]            diff;
  logic [thpid_pkg::ADC_W-1:0]     seg_adc;
  logic [5:0]                      seg_dist;
  logic [8:0]                      dt;
  logic [TW-1:0]                   base;
  logic                            target_on;

  thpid_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign target_on = cfg.target_temp > thpid_pkg::ROOM_TEMP_DEG;
  assign err  = $signed({4'b0000, cfg.target_temp, 4'b0000}) - $signed({2'b00, cur_q});
  assign diff = $signed({2'b00, cur_q}) - $signed({2'b00, prev_q});

  assign seg_adc  = thpid_pkg::lut_adc(seg_q);
  assign seg_dist = 6'(seg_adc - x_q);
  assign dt       = 9'(thpid_pkg::lut_deg(seg_q - thpid_pkg::SEG_W'(1))
                       - thpid_pkg::lut_deg(seg_q));
  assign base     = TW'({thpid_pkg::lut_deg(seg_q), 4'b0000});

  assign mul_p = mul_a * mul_b;

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    glitch_d    = glitch_q;
    sflt_d      = sflt_q;
    rflt_d      = rflt_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    win_d       = win_q;
    idx_d       = idx_q;
    isum_d      = isum_q;
    duty_d      = duty_q;
    x_d         = x_q;
    seg_d       = seg_q;
    acc_d       = acc_q;
    mul_a       = '0;
    mul_b       = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    out_duty_d  = out_duty_q;
    out_temp_d  = out_temp_q;
    out_act_d   = out_act_q;
    out_sflt_d  = out_sflt_q;
    out_rflt_d  = out_rflt_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          x_d     = adc_sample_i;
          state_d = S_ENTRY;
        end
      end
      S_ENTRY: begin
        state_d = S_SAMPLE;
        if (mode_q) begin
          if (!target_on) begin
            mode_d = 1'b0;
            duty_d = '0;
          end else begin
            mul_a   = MW'(cfg.integral_gain);
            mul_b   = MW'(win_q[idx_q]);
            state_d = S_ISUB;
          end
        end
      end
      S_ISUB: begin
        isum_d  = isum_q - mul_q[IW-1:0];
        state_d = S_SAMPLE;
      end
      S_SAMPLE: begin
        if (x_q >= cfg.adc_cutoff) begin
          if (glitch_q < thpid_pkg::GLITCH_MAX) begin
            glitch_d = glitch_q + thpid_pkg::GCNT_W'(1);
          end
          if (glitch_d > thpid_pkg::GLITCH_LIMIT) begin
            sflt_d = 1'b1;
          end
          state_d = S_MODE;
        end else begin
          glitch_d = '0;
          prev_d   = cur_q;
          if (x_q < thpid_pkg::lut_adc('0)) begin
            x_d = thpid_pkg::lut_adc('0);
          end
          seg_d   = thpid_pkg::SEG_W'(1);
          state_d = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (seg_adc >= x_q) begin
          mul_a   = MW'(dt);
          mul_b   = MW'(seg_dist);
          state_d = S_SCALE;
        end else if (seg_q == thpid_pkg::SEG_W'(thpid_pkg::TABLE_POINTS - 1)) begin
          state_d = S_MODE;
        end else begin
          seg_d = seg_q + thpid_pkg::SEG_W'(1);
        end
      end
      S_SCALE: begin
        mul_a   = MW'({mul_q[14:0], 4'b0000});
        mul_b   = thpid_pkg::RECIP_53;
        state_d = S_INTERP;
      end
      S_INTERP: begin
        cur_d   = base + mul_q[thpid_pkg::RECIP_SHIFT +: TW];
        state_d = S_MODE;
      end
      S_MODE: begin
        state_d = S_DONE;
        if (sflt_q || rflt_q) begin
          mode_d = 1'b0;
          duty_d = '0;
        end else if (!mode_q) begin
          if (target_on) begin
            mode_d = 1'b1;
            duty_d = thpid_pkg::MAX_DUTY;
          end
        end else if (cur_q > thpid_pkg::MAX_TEMP_16) begin
          rflt_d = 1'b1;
          mode_d = 1'b0;
          duty_d = '0;
        end else begin
          win_d[idx_q] = err;
          idx_d = (idx_q == thpid_pkg::IDX_W'(thpid_pkg::ERROR_WINDOW - 1)) ?
                  '0 : idx_q + thpid_pkg::IDX_W'(1);
          mul_a   = MW'(cfg.integral_gain);
          mul_b   = MW'(err);
          state_d = S_IADD;
        end
      end
      S_IADD: begin
        isum_d  = isum_q + mul_q[IW-1:0];
        mul_a   = MW'(cfg.prop_gain);
        mul_b   = MW'(err);
        state_d = S_PTERM;
      end
      S_PTERM: begin
        acc_d   = mul_q + PW'($signed(isum_q));
        mul_a   = MW'(cfg.deriv_gain);
        mul_b   = MW'(diff);
        state_d = S_DTERM;
      end
      S_DTERM: begin
        acc_d   = acc_q - mul_q;
        state_d = S_DUTY;
      end
      S_DUTY: begin
        if (acc_q <= 0) begin
          duty_d = '0;
        end else if (acc_q[PW-1:12] > (PW-12)'(thpid_pkg::MAX_DUTY)) begin
          duty_d = thpid_pkg::MAX_DUTY;
        end else begin
          duty_d = acc_q[12 +: thpid_pkg::DUTY_W];
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_duty_d  = duty_q;
          out_temp_d  = cur_q;
          out_act_d   = mode_q;
          out_sflt_d  = sflt_q;
          out_rflt_d  = rflt_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= 1'b0;
      glitch_q    <= '0;
      sflt_q      <= 1'b0;
      rflt_q      <= 1'b0;
      cur_q       <= '0;
      prev_q      <= '0;
      win_q       <= '{default: '0};
      idx_q       <= '0;
      isum_q      <= '0;
      duty_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      glitch_q    <= glitch_d;
      sflt_q      <= sflt_d;
      rflt_q      <= rflt_d;
      cur_q       <= cur_d;
      prev_q      <= prev_d;
      win_q       <= win_d;
      idx_q       <= idx_d;
      isum_q      <= isum_d;
      duty_q      <= duty_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    seg_q      <= seg_d;
    acc_q      <= acc_d;
    mul_q      <= mul_p;
    out_duty_q <= out_duty_d;
    out_temp_q <= out_temp_d;
    out_act_q  <= out_act_d;
    out_sflt_q <= out_sflt_d;
    out_rflt_q <= out_rflt_d;
  end

  assign in_ready_o      = (state_q == S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign heater_duty_o   = out_duty_q;
  assign temperature_o   = out_temp_q;
  assign heater_active_o = out_act_q;
  assign sensor_fault_o  = out_sflt_q;
  assign runaway_fault_o = out_rflt_q;

  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("sequencer took a second transaction while busy");

  a_duty_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> heater_duty_o <= thpid_pkg::MAX_DUTY)
    else $error("heater duty above full scale");

  a_fault_off : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (sensor_fault_o || runaway_fault_o) |->
      heater_duty_o == '0 && !heater_active_o)
    else $error("heater driven while a fault is latched");

  a_glitch_sat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    glitch_q <= thpid_pkg::GLITCH_MAX)
    else $error("glitch counter past saturation");

  a_fault_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sflt_q || rflt_q |=> sflt_q || rflt_q)
    else $error("fault latch dropped without reset");

endmodule

>>> bench/thpid_checker.sv
// ----------------------------------------------------------------------------
// Thermistor PID heater control checker
// Watches the sample, result and register ports of the heater control unit.
// Keeps its own copy of the controller state, predicts each result and
// compares it with what the unit delivers. It reports failures and the
// number of predictions still pending.
// ----------------------------------------------------------------------------
module thpid_checker
  import thpid_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [ADC_W-1:0]   adc_sample_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [DUTY_W-1:0]  heater_duty_i,
  input  logic [TEMP_W-1:0]  temperature_i,
  input  logic               heater_active_i,
  input  logic               sensor_fault_i,
  input  logic               runaway_fault_i,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  input  logic               pready,
  output int                 errors_o,
  output int                 pending_o,
  output int                 checked_o
);

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic [TEMP_W-1:0] temp;
    logic              active;
    logic              sensor;
    logic              runaway;
  } tick_result_t;

  int deg_tab [TABLE_POINTS] = '{713, 236, 195, 172, 157, 144, 134, 125, 117, 110,
                                 103, 96, 89, 83, 75, 68, 59, 48, 34, 3};

  logic [7:0]        tgt;
  logic [ADC_W-1:0]  cutoff;
  logic [15:0]       kp, ki, kd;
  bit                ctl_on, sflt, rflt;
  int                glitches, cur_t, prev_t, widx, duty;
  int                err_win [ERROR_WINDOW];
  logic [ISUM_W-1:0] isum;
  tick_result_t      duty_forecast_q [$];
  int                fails, checked;

  function automatic int linearize(input int x, input int cur);
    int hi_adc;
    if (x < 1) x = 1;
    for (int k = 1; k < TABLE_POINTS; k++) begin
      hi_adc = 1 + ADC_STEP * k;
      if (hi_adc >= x) begin
        return (deg_tab[k] * 16 + ((deg_tab[k-1] - deg_tab[k]) * 16 * (hi_adc - x)) / ADC_STEP)
               & 16'h3FFF;
      end
    end
    return cur;
  endfunction

  task automatic advance_controller(input int x, output tick_result_t r);
    int     k, err, diff;
    longint pid;
    k = widx;
    if (ctl_on) begin
      if (tgt <= ROOM_TEMP_DEG) begin
        ctl_on = 0;
        duty = 0;
      end else begin
        isum = isum - longint'(ki) * longint'(err_win[k]);
      end
    end
    if (x >= cutoff) begin
      if (glitches < 4) glitches++;
      if (glitches > 3) sflt = 1;
    end else begin
      glitches = 0;
      prev_t = cur_t;
      cur_t = linearize(x, cur_t);
    end
    if (sflt || rflt) begin
      ctl_on = 0;
      duty = 0;
    end else if (!ctl_on) begin
      if (tgt > ROOM_TEMP_DEG) begin
        ctl_on = 1;
        duty = MAX_DUTY;
      end
    end else if (cur_t > int'(MAX_TEMP_16)) begin
      rflt = 1;
      ctl_on = 0;
      duty = 0;
    end else begin
      err = int'(tgt) * 16 - cur_t;
      diff = cur_t - prev_t;
      err_win[k] = err;
      widx = (k + 1) % ERROR_WINDOW;
      isum = isum + longint'(ki) * longint'(err);
      pid = longint'(kp) * err + longint'($signed(isum)) - longint'(kd) * diff;
      if (pid <= 0) duty = 0;
      else duty = ((pid >>> 12) > 100) ? 100 : int'(pid >>> 12);
    end
    r.duty = duty;
    r.temp = cur_t;
    r.active = ctl_on;
    r.sensor = sflt;
    r.runaway = rflt;
  endtask

  task automatic report(input string what, input tick_result_t want, input tick_result_t got);
    fails++;
    if (fails <= 10) begin
      $display("%0t %s: expected duty=%0d temp=%0d active=%0b sensor=%0b runaway=%0b", $time,
               what, want.duty, want.temp, want.active, want.sensor, want.runaway);
      $display("%0t %s: actual   duty=%0d temp=%0d active=%0b sensor=%0b runaway=%0b", $time,
               what, got.duty, got.temp, got.active, got.sensor, got.runaway);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    tick_result_t want, got;
    if (!rst_ni) begin
      tgt = '0;
      cutoff = CUTOFF_RESET;
      kp = '0;
      ki = '0;
      kd = '0;
      ctl_on = 0;
      sflt = 0;
      rflt = 0;
      glitches = 0;
      cur_t = 0;
      prev_t = 0;
      widx = 0;
      duty = 0;
      isum = '0;
      for (int k = 0; k < ERROR_WINDOW; k++) err_win[k] = 0;
      duty_forecast_q.delete();
      fails = 0;
      checked = 0;
      errors_o <= 0;
      pending_o <= 0;
      checked_o <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[PADDR_W-1:2])
          REG_TARGET: tgt = pwdata[7:0];
          REG_CUTOFF: cutoff = pwdata[ADC_W-1:0];
          REG_PGAIN:  kp = pwdata[15:0];
          REG_IGAIN:  ki = pwdata[15:0];
          REG_DGAIN:  kd = pwdata[15:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        got = '{heater_duty_i, temperature_i, heater_active_i, sensor_fault_i, runaway_fault_i};
        if (duty_forecast_q.size() == 0) begin
          report("unexpected result", '0, got);
        end else begin
          want = duty_forecast_q.pop_front();
          checked++;
          if (got !== want) report("mismatch", want, got);
        end
      end
      if (in_valid_i && in_ready_i) begin
        advance_controller(int'(adc_sample_i), want);
        duty_forecast_q.push_back(want);
      end
      errors_o <= fails;
      pending_o <= duty_forecast_q.size();
      checked_o <= checked;
    end
  end

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// Thermistor PID heater control testbench
// Drives thermistor samples and register settings into the heater control
// unit with random idling on both channels. A directed pass covers the table
// ends, glitch runs and the first active tick; random phases then sweep
// target, cutoff and gain settings; a closing pass latches both faults.
// ----------------------------------------------------------------------------
module tb;
  import thpid_pkg::*;

  localparam logic [2:0] REG_SPARE = 3'd7;
  localparam int         SAFE_MIN  = 62;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [ADC_W-1:0]   adc_sample_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [DUTY_W-1:0]  heater_duty_o;
  logic [TEMP_W-1:0]  temperature_o;
  logic               heater_active_o;
  logic               sensor_fault_o;
  logic               runaway_fault_o;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int errors, pending, checked;
  int items_sent = 0;
  int phases = 0;
  int cur_cutoff = CUTOFF_RESET;
  int glitch_run = 0;
  bit hold_done = 0;
  int hold_left = 0;

  int off_points [15] = '{0, 1, 2, 53, 54, 55, 61, 107, 1008, 1009, 999, 1000, 1023, 1022, 512};
  int on_points  [10] = '{500, 62, 1008, 1009, 1022, 1023, 1023, 1023, 300, 700};

  thermistor_pid_heater_control_unit DUT (.*);

  thpid_checker u_checker (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_i      (in_ready_o),
    .adc_sample_i,
    .out_valid_i     (out_valid_o),
    .out_ready_i,
    .heater_duty_i   (heater_duty_o),
    .temperature_i   (temperature_o),
    .heater_active_i (heater_active_o),
    .sensor_fault_i  (sensor_fault_o),
    .runaway_fault_i (runaway_fault_o),
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .pready,
    .errors_o        (errors),
    .pending_o       (pending),
    .checked_o       (checked)
  );

  always #5 clk_i = ~clk_i;

  function automatic int idle_pct(input bit receiver);
    if (items_sent < 300) return receiver ? 52 : 11;
    if (items_sent < 600) return receiver ? 11 : 52;
    return 0;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && !hold_done && items_sent >= 400) begin
      hold_done <= 1;
      hold_left <= 300;
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= idle_pct(1));
    end
  end

  task automatic send_sample(input int s);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct(0)) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    adc_sample_i <= s[ADC_W-1:0];
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    glitch_run = (s >= cur_cutoff) ? glitch_run + 1 : 0;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic apb_write(input logic [2:0] idx, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
  endtask

  task automatic configure(input int tgt, input int cut, input logic [15:0] kp,
                           input logic [15:0] ki, input logic [15:0] kd, input bit spare);
    wait_drained();
    apb_write(REG_TARGET, tgt);
    apb_write(REG_CUTOFF, cut);
    apb_write(REG_PGAIN, kp);
    apb_write(REG_IGAIN, ki);
    apb_write(REG_DGAIN, kd);
    if (spare) apb_write(REG_SPARE, $urandom);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cur_cutoff = cut;
    phases++;
  endtask

  function automatic int pick_sample(input bit active);
    int r, s;
    r = $urandom_range(99);
    if (r < 70) begin
      s = $urandom_range(cur_cutoff - 1, 0);
    end else if (r < 80) begin
      s = $urandom_range(1023, cur_cutoff);
    end else if (r < 90) begin
      s = 1 + ADC_STEP * $urandom_range(TABLE_POINTS - 1) + $urandom_range(2) - 1;
    end else begin
      case ($urandom_range(6))
        0: s = 0;
        1: s = 1;
        2: s = SAFE_MIN;
        3: s = 1008;
        4: s = 1009;
        5: s = 1022;
        default: s = 1023;
      endcase
    end
    if (active && s < SAFE_MIN) s = s + SAFE_MIN;
    if (glitch_run >= 3 && s >= cur_cutoff) begin
      s = $urandom_range(cur_cutoff - 1, active ? SAFE_MIN : 0);
    end
    return s;
  endfunction

  initial begin
    int          tgt, cut;
    bit          active;
    logic [15:0] kp, ki, kd;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (off_points[k]) send_sample(off_points[k]);
    configure(255, 1023, 16'h0100, 16'h0040, 16'h0200, 0);
    foreach (on_points[k]) send_sample(on_points[k]);

    for (int p = 0; p < 20; p++) begin
      if (p == 0) tgt = 31;
      else if (p == 1) tgt = 255;
      else if (p % 4 == 3) tgt = ($urandom_range(1)) ? $urandom_range(30) : 30;
      else if (p == 6) tgt = 0;
      else tgt = $urandom_range(255, 31);
      active = (tgt > ROOM_TEMP_DEG);
      if (p % 5 == 0) cut = 1023;
      else if (p % 5 == 1) cut = 100;
      else cut = $urandom_range(1023, 100);
      if (p == 2) begin
        kp = '0;
        ki = '0;
        kd = '0;
      end else if (p == 4) begin
        kp = 16'hFFFF;
        ki = 16'hFFFF;
        kd = 16'hFFFF;
      end else if ($urandom_range(1)) begin
        kp = $urandom_range(1023);
        ki = $urandom_range(1023);
        kd = $urandom_range(1023);
      end else begin
        kp = $urandom;
        ki = $urandom;
        kd = $urandom;
      end
      configure(tgt, cut, kp, ki, kd, p == 7);
      send_sample(active ? $urandom_range(cur_cutoff - 1, SAFE_MIN) : pick_sample(0));
      for (int k = 1; k < 40; k++) begin
        if (p == 5 && k == 20) wait_drained();
        send_sample(pick_sample(active));
      end
    end

    configure(200, 1000, 16'h0100, 16'h0010, 16'h0080, 0);
    send_sample(500);
    send_sample(300);
    send_sample(0);
    send_sample(700);
    send_sample(40);
    configure(200, 0, 16'h0100, 16'h0010, 16'h0080, 0);
    repeat (5) send_sample($urandom_range(1023));
    configure(0, 1000, 16'h0100, 16'h0010, 16'h0080, 0);
    repeat (10) send_sample($urandom_range(1023));

    wait_drained();
    repeat (64) @(posedge clk_i);
    $display("checked %0d results from %0d samples across %0d register settings", checked,
             items_sent, phases);
    $display("run swept table ends, glitch runs, gain extremes, runaway and sensor fault latch");
    if (errors == 0 && pending == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("tb failed");
    $finish;
  end

endmodule
